// File: design/assert_macros.svh
// Assertion macros for the checker file of the serial MP3 controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, held off while reset is asserted.
`define SMC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: design/smc_pkg.sv
// Types, codes and constants shared by the serial MP3 controller modules.
`default_nettype none

package smc_pkg;

  localparam int TickCountWidthDef = 32;
  localparam int QueueDepth        = 2;

  localparam logic [7:0] FrameStart   = 8'h7E;
  localparam logic [7:0] FrameVersion = 8'hFF;
  localparam logic [7:0] FrameLength  = 8'h06;
  localparam logic [7:0] FrameEnd     = 8'hEF;

  localparam logic [7:0] CmdPlayFolder = 8'h0F;
  localparam logic [7:0] CmdStop       = 8'h16;
  localparam logic [7:0] CmdPause      = 8'h0E;
  localparam logic [7:0] CmdResume     = 8'h0D;
  localparam logic [7:0] CmdVolume     = 8'h06;
  localparam logic [7:0] CmdFeedback   = 8'h41;
  localparam logic [7:0] RptFinished   = 8'h3D;
  localparam logic [7:0] RptError      = 8'h40;

  localparam logic [7:0]  MaxVolume     = 8'd30;
  localparam logic [7:0]  MinIndex      = 8'd1;
  localparam logic [7:0]  MaxIndex      = 8'd99;
  localparam logic [15:0] MarginResetMs = 16'd300;

  localparam logic [3:0] RxFirstPos  = 4'd0;
  localparam logic [3:0] RxCmdPos    = 4'd3;
  localparam logic [3:0] RxParHiPos  = 4'd5;
  localparam logic [3:0] RxParLoPos  = 4'd6;
  localparam logic [3:0] RxLastPos   = 4'd9;

  // Byte positions within a transmitted command frame
  localparam logic [3:0] TxStartPos  = 4'd0;
  localparam logic [3:0] TxVerPos    = 4'd1;
  localparam logic [3:0] TxLenPos    = 4'd2;
  localparam logic [3:0] TxCmdPos    = 4'd3;
  localparam logic [3:0] TxAckPos    = 4'd4;
  localparam logic [3:0] TxParHiPos  = 4'd5;
  localparam logic [3:0] TxParLoPos  = 4'd6;
  localparam logic [3:0] TxSumHiPos  = 4'd7;
  localparam logic [3:0] TxSumLoPos  = 4'd8;
  localparam logic [3:0] TxEndPos    = 4'd9;

  // Register select, taken from paddr[2]
  localparam logic RegExpected = 1'b0;
  localparam logic RegMargin   = 1'b1;

  typedef enum logic [2:0] {
    ReqPlay     = 3'd0,
    ReqStop     = 3'd1,
    ReqPause    = 3'd2,
    ReqResume   = 3'd3,
    ReqVolume   = 3'd4,
    ReqFeedback = 3'd5,
    ReqRxByte   = 3'd6,
    ReqTick     = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    RespNone     = 3'd0,
    RespAck      = 3'd1,
    RespFinished = 3'd2,
    RespError    = 3'd3,
    RespDropped  = 3'd4
  } resp_kind_e;

  typedef struct packed {
    req_e       req_type;
    logic [7:0] folder_number;
    logic [7:0] track_number;
    logic [7:0] volume_level;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic        play_rejected;
    resp_kind_e  resp_kind;
    logic [7:0]  resp_cmd;
    logic [15:0] resp_param;
    logic        playing;
  } out_word_t;

  // Work handed from the front to the back: a command frame or a single result word
  typedef struct packed {
    logic        is_frame;
    logic        play_rejected;
    resp_kind_e  kind;
    logic [7:0]  cmd;
    logic [15:0] param;
    logic        ack;
    logic        playing;
  } job_t;

endpackage

`default_nettype wire

// File: design/serial_mp3_module_controller.sv
// Top level of the serial MP3 module controller: config registers, front, queue, back.
`default_nettype none
//
//  Channel   Direction  Handshake                 Word
//  --------  ---------  ------------------------  ---------------------------------
//  request   in         push / full               in_word_i  (smc_pkg::in_word_t)
//  result    out        empty / pop               out_word_o (smc_pkg::out_word_t)
//  config    in         APB psel/penable/pwrite   expected_ms @0x0, margin_ms @0x4
//
//  A command request gives ten result words, one per cycle while pop is held;
//  any other request gives one word. The frame sender in the back end sets this
//  figure: it steps one frame byte per cycle out of a two-entry job queue.
//  A request is taken in the cycle it arrives unless the job queue is full, so
//  requests keep flowing while the back end is still sending earlier frames.
//  Reset is asynchronous and active low; it clears the playing flag, the tick
//  counter, the receive hunt position, the queue and the output valid flag.
//  A stalled result (empty low, pop low) holds the output register steady.

module serial_mp3_module_controller import smc_pkg::*; #(
  parameter int TickCountWidth = TickCountWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire in_word_t    in_word_i,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output out_word_t        out_word_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] expected_ms_q;
  logic [15:0] margin_ms_q;
  logic        cfg_wr;
  logic        accept;
  job_t        front_job, back_job;
  logic        job_avail, job_empty, job_pop;

  // Configuration registers: word select on paddr[2], low address bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegMargin) ? {16'd0, margin_ms_q} : expected_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_ms_q <= 32'd0;
      margin_ms_q   <= MarginResetMs;
    end else if (cfg_wr) begin
      if (paddr[2] == RegExpected) begin
        expected_ms_q <= pwdata;
      end else begin
        margin_ms_q <= pwdata[15:0];
      end
    end
  end

  // Take a request whenever the job queue has room
  assign accept = push && !full;

  smc_front #(
    .TickCountWidth(TickCountWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_word_i    (in_word_i),
    .expected_ms_i(expected_ms_q),
    .margin_ms_i  (margin_ms_q),
    .job_o        (front_job)
  );

  smc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_data_i(front_job),
    .full_o   (full),
    .rd_i     (job_pop),
    .rd_data_o(back_job),
    .empty_o  (job_empty)
  );

  assign job_avail = !job_empty;

  // Expand jobs into words; drop a job from the queue on its last word
  smc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (back_job),
    .job_avail_i(job_avail),
    .job_pop_o  (job_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .word_o     (out_word_o)
  );

endmodule

`default_nettype wire

// File: design/smc_front.sv
// Front end: accepts request words, updates player state and queues jobs.
`default_nettype none

module smc_front import smc_pkg::*; #(
  parameter int TickCountWidth = TickCountWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire in_word_t    in_word_i,
  input  wire logic [31:0] expected_ms_i,
  input  wire logic [15:0] margin_ms_i,
  output job_t             job_o
);

  localparam int CmpW = (TickCountWidth > 33) ? TickCountWidth : 33;

  logic                      playing_q, playing_d;
  logic [TickCountWidth-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [3:0]                rx_pos_q, rx_pos_d;
  logic [7:0]                rx_cmd_q, rx_ph_q, rx_pl_q;
  logic [32:0]               limit;
  logic                      timed_out;
  logic [7:0]                vol;
  logic                      play_ok;

  assign elapsed_inc = elapsed_q + 1'b1;
  assign limit       = {1'b0, expected_ms_i} + {17'd0, margin_ms_i};
  assign timed_out   = (expected_ms_i != 32'd0) &&
                       (CmpW'(elapsed_inc) > CmpW'(limit));
  assign vol         = (in_word_i.volume_level > MaxVolume) ? MaxVolume
                                                            : in_word_i.volume_level;
  assign play_ok     = (in_word_i.folder_number inside {[MinIndex:MaxIndex]}) &&
                       (in_word_i.track_number inside {[MinIndex:MaxIndex]});

  always_comb begin
    playing_d = playing_q;
    elapsed_d = elapsed_q;
    rx_pos_d  = rx_pos_q;
    job_o     = '0;
    job_o.is_frame = 1'b1;
    job_o.ack      = 1'b1;
    job_o.kind     = RespNone;
    case (in_word_i.req_type)
      ReqPlay: begin
        if (play_ok) begin
          playing_d   = 1'b1;
          elapsed_d   = '0;
          job_o.cmd   = CmdPlayFolder;
          job_o.param = {in_word_i.folder_number, in_word_i.track_number};
        end else begin
          job_o.is_frame      = 1'b0;
          job_o.play_rejected = 1'b1;
        end
      end
      ReqStop: begin
        playing_d = 1'b0;
        job_o.cmd = CmdStop;
      end
      ReqPause: begin
        playing_d = 1'b0;
        job_o.cmd = CmdPause;
      end
      ReqResume: begin
        playing_d = 1'b1;
        job_o.cmd = CmdResume;
      end
      ReqVolume: begin
        job_o.cmd   = CmdVolume;
        job_o.param = {8'd0, vol};
      end
      ReqFeedback: begin
        job_o.cmd   = CmdFeedback;
        job_o.param = 16'd1;
        job_o.ack   = 1'b0;
      end
      ReqRxByte: begin
        job_o.is_frame = 1'b0;
        if (rx_pos_q == RxFirstPos && in_word_i.rx_byte != FrameStart) begin
          rx_pos_d = RxFirstPos;
        end else if (rx_pos_q != RxLastPos) begin
          rx_pos_d = rx_pos_q + 4'd1;
        end else begin
          rx_pos_d = RxFirstPos;
          if (in_word_i.rx_byte != FrameEnd) begin
            job_o.kind = RespDropped;
          end else begin
            job_o.cmd   = rx_cmd_q;
            job_o.param = {rx_ph_q, rx_pl_q};
            if (rx_cmd_q == RptFinished) begin
              job_o.kind = RespFinished;
              playing_d  = 1'b0;
            end else if (rx_cmd_q == RptError) begin
              job_o.kind = RespError;
              playing_d  = 1'b0;
            end else begin
              job_o.kind = RespAck;
            end
          end
        end
      end
      ReqTick: begin
        job_o.is_frame = 1'b0;
        elapsed_d      = elapsed_inc;
        if (playing_q && timed_out) begin
          playing_d = 1'b0;
        end
      end
      default: begin
        job_o.is_frame = 1'b0;
      end
    endcase
    job_o.playing = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      elapsed_q <= '0;
      rx_pos_q  <= RxFirstPos;
    end else if (accept_i) begin
      playing_q <= playing_d;
      elapsed_q <= elapsed_d;
      rx_pos_q  <= rx_pos_d;
    end
  end

  // Captured frame bytes; only read once a whole frame has been gathered
  always_ff @(posedge clk_i) begin
    if (accept_i && in_word_i.req_type == ReqRxByte) begin
      if (rx_pos_q == RxCmdPos) begin
        rx_cmd_q <= in_word_i.rx_byte;
      end
      if (rx_pos_q == RxParHiPos) begin
        rx_ph_q <= in_word_i.rx_byte;
      end
      if (rx_pos_q == RxParLoPos) begin
        rx_pl_q <= in_word_i.rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/smc_queue.sv
// Short job queue between the front end and the frame sender.
`default_nettype none

module smc_queue import smc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire job_t wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output job_t      rd_data_o,
  output logic      empty_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/smc_back.sv
// Back end: expands queued jobs into result words and holds the output register.
`default_nettype none

module smc_back import smc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic job_avail_i,
  output logic      job_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output out_word_t word_o
);

  logic [3:0]  idx_q;
  logic        out_valid_q;
  out_word_t   out_q, word_d;
  logic        advance, load, last;
  logic [15:0] sum, csum;
  logic [7:0]  tx_byte;

  assign sum  = 16'(FrameVersion) + 16'(FrameLength) + 16'(job_i.cmd) +
                16'(job_i.ack) + 16'(job_i.param[15:8]) + 16'(job_i.param[7:0]);
  assign csum = 16'd0 - sum;

  always_comb begin
    case (idx_q)
      TxStartPos: tx_byte = FrameStart;
      TxVerPos:   tx_byte = FrameVersion;
      TxLenPos:   tx_byte = FrameLength;
      TxCmdPos:   tx_byte = job_i.cmd;
      TxAckPos:   tx_byte = {7'd0, job_i.ack};
      TxParHiPos: tx_byte = job_i.param[15:8];
      TxParLoPos: tx_byte = job_i.param[7:0];
      TxSumHiPos: tx_byte = csum[15:8];
      TxSumLoPos: tx_byte = csum[7:0];
      TxEndPos:   tx_byte = FrameEnd;
      default:    tx_byte = FrameEnd;
    endcase
  end

  always_comb begin
    word_d = '0;
    word_d.playing = job_i.playing;
    if (job_i.is_frame) begin
      word_d.tx_valid    = 1'b1;
      word_d.tx_byte     = tx_byte;
      word_d.last_of_run = (idx_q == TxEndPos);
      word_d.resp_kind   = RespNone;
    end else begin
      word_d.last_of_run   = 1'b1;
      word_d.play_rejected = job_i.play_rejected;
      word_d.resp_kind     = job_i.kind;
      word_d.resp_cmd      = job_i.cmd;
      word_d.resp_param    = job_i.param;
    end
  end

  assign advance   = !out_valid_q || pop_i;
  assign load      = advance && job_avail_i;
  assign last      = word_d.last_of_run;
  assign job_pop_o = load && last;
  assign empty_o   = !out_valid_q;
  assign word_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= TxStartPos;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= job_avail_i;
      if (load) begin
        idx_q <= last ? TxStartPos : idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= word_d;
    end
  end

endmodule

`default_nettype wire

// File: design/smc_checker.sv
// Port-level checks for the serial MP3 controller, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module smc_checker import smc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire out_word_t   out_word_o
);

  logic mid_frame_pop;
  logic stalled;

  assign mid_frame_pop = pop && !empty && out_word_o.tx_valid && !out_word_o.last_of_run;
  assign stalled       = !empty && !pop;

  // Frame bytes follow one another with no gap
  `SMC_ASSERT_NXT(a_frame_continues, clk_i, rst_ni, mid_frame_pop, !empty && out_word_o.tx_valid)
  // Playing flag stays the same across the words of one frame
  `SMC_ASSERT_NXT(a_frame_playing_steady, clk_i, rst_ni, mid_frame_pop, $stable(out_word_o.playing))
  // A waiting result holds until taken
  `SMC_ASSERT_NXT(a_result_holds, clk_i, rst_ni, stalled, !empty && $stable(out_word_o))

endmodule

bind serial_mp3_module_controller smc_checker u_smc_checker (.*);

`default_nettype wire

// File: dv/serial_mp3_module_controller_test.sv
// Self-checking testbench for the serial MP3 module controller.
`timescale 1ns / 1ps

module serial_mp3_module_controller_test;
  import smc_pkg::*;

  localparam int ClockHalfPeriod = 10;
  localparam int ResetCycles     = 8;
  localparam int SettleCycles    = 4;
  localparam int EndSettleCycles = 40;
  localparam int QuietLimit      = 1000;
  localparam int PhaseWords      = 106;

  // Byte addresses of the configuration registers
  localparam logic [2:0] AddrExpected = 3'h0;
  localparam logic [2:0] AddrMargin   = 3'h4;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_word_t    in_word_i;
  logic        empty;
  logic        pop;
  out_word_t   out_word_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  serial_mp3_module_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Idling odds in percent, changed per phase
  int source_gap_pct = 15;
  int sink_stall_pct = 50;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  // Predicted result words, oldest first
  out_word_t words_due[$];

  // Shadow of the controller: registers, playing flag, tick count, receive hunt
  logic [31:0]                  shadow_expected_ms;
  logic [15:0]                  shadow_margin_ms;
  logic                         shadow_playing;
  logic [TickCountWidthDef-1:0] shadow_elapsed_ms;
  logic [3:0]                   shadow_rx_pos;
  logic [7:0]                   shadow_rx_frame [10];

  initial begin
    clk_i = 1'b0;
    forever #ClockHalfPeriod clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Queue one result word; it carries the playing flag as it stands now.
  function automatic void queue_word(logic txv, logic [7:0] txb, logic last, logic rej,
                                     resp_kind_e kind, logic [7:0] cmd, logic [15:0] param);
    out_word_t w;
    w.tx_valid      = txv;
    w.tx_byte       = txb;
    w.last_of_run   = last;
    w.play_rejected = rej;
    w.resp_kind     = kind;
    w.resp_cmd      = cmd;
    w.resp_param    = param;
    w.playing       = shadow_playing;
    words_due.push_back(w);
  endfunction

  // Queue the ten bytes of a command frame; the checksum is the negated 16-bit sum
  // of every byte between the start and the checksum itself.
  function automatic void queue_frame(logic [7:0] cmd, logic [15:0] param, logic ack);
    logic [7:0]  bytes [10];
    logic [15:0] sum;
    bytes[TxStartPos] = FrameStart;
    bytes[TxVerPos]   = FrameVersion;
    bytes[TxLenPos]   = FrameLength;
    bytes[TxCmdPos]   = cmd;
    bytes[TxAckPos]   = {7'd0, ack};
    bytes[TxParHiPos] = param[15:8];
    bytes[TxParLoPos] = param[7:0];
    sum = 16'(bytes[TxVerPos]) + 16'(bytes[TxLenPos]) + 16'(bytes[TxCmdPos])
        + 16'(bytes[TxAckPos]) + 16'(bytes[TxParHiPos]) + 16'(bytes[TxParLoPos]);
    sum = 16'd0 - sum;
    bytes[TxSumHiPos] = sum[15:8];
    bytes[TxSumLoPos] = sum[7:0];
    bytes[TxEndPos]   = FrameEnd;
    for (int i = 0; i < 10; i++) begin
      queue_word(1'b1, bytes[i], i == 9, 1'b0, RespNone, 8'h00, 16'h0000);
    end
  endfunction

  function automatic void predict_words(in_word_t w);
    logic [7:0]                 vol;
    logic [TickCountWidthDef:0] limit;
    resp_kind_e                 kind;
    case (w.req_type)
      ReqPlay: begin
        if (w.folder_number < MinIndex || w.folder_number > MaxIndex ||
            w.track_number < MinIndex || w.track_number > MaxIndex) begin
          queue_word(1'b0, 8'h00, 1'b1, 1'b1, RespNone, 8'h00, 16'h0000);
        end else begin
          shadow_playing    = 1'b1;
          shadow_elapsed_ms = '0;
          queue_frame(CmdPlayFolder, {w.folder_number, w.track_number}, 1'b1);
        end
      end
      ReqStop: begin
        shadow_playing = 1'b0;
        queue_frame(CmdStop, 16'h0000, 1'b1);
      end
      ReqPause: begin
        shadow_playing = 1'b0;
        queue_frame(CmdPause, 16'h0000, 1'b1);
      end
      ReqResume: begin
        shadow_playing = 1'b1;
        queue_frame(CmdResume, 16'h0000, 1'b1);
      end
      ReqVolume: begin
        vol = (w.volume_level > MaxVolume) ? MaxVolume : w.volume_level;
        queue_frame(CmdVolume, {8'h00, vol}, 1'b1);
      end
      ReqFeedback: begin
        queue_frame(CmdFeedback, 16'h0001, 1'b0);
      end
      ReqRxByte: begin
        if (shadow_rx_pos == RxFirstPos && w.rx_byte != FrameStart) begin
          queue_word(1'b0, 8'h00, 1'b1, 1'b0, RespNone, 8'h00, 16'h0000);
        end else begin
          shadow_rx_frame[shadow_rx_pos] = w.rx_byte;
          if (shadow_rx_pos < RxLastPos) begin
            shadow_rx_pos = shadow_rx_pos + 4'd1;
            queue_word(1'b0, 8'h00, 1'b1, 1'b0, RespNone, 8'h00, 16'h0000);
          end else begin
            // frame complete: hunt again from the next byte
            shadow_rx_pos = RxFirstPos;
            if (w.rx_byte != FrameEnd) begin
              queue_word(1'b0, 8'h00, 1'b1, 1'b0, RespDropped, 8'h00, 16'h0000);
            end else begin
              kind = RespAck;
              if (shadow_rx_frame[RxCmdPos] == RptFinished) begin
                kind           = RespFinished;
                shadow_playing = 1'b0;
              end else if (shadow_rx_frame[RxCmdPos] == RptError) begin
                kind           = RespError;
                shadow_playing = 1'b0;
              end
              queue_word(1'b0, 8'h00, 1'b1, 1'b0, kind, shadow_rx_frame[RxCmdPos],
                         {shadow_rx_frame[RxParHiPos], shadow_rx_frame[RxParLoPos]});
            end
          end
        end
      end
      ReqTick: begin
        // the limit never wraps, the tick count does
        limit = (TickCountWidthDef + 1)'(shadow_expected_ms)
              + (TickCountWidthDef + 1)'(shadow_margin_ms);
        shadow_elapsed_ms = shadow_elapsed_ms + 1'b1;
        if (shadow_playing && shadow_expected_ms != 32'd0 &&
            {1'b0, shadow_elapsed_ms} > limit) begin
          shadow_playing = 1'b0;
        end
        queue_word(1'b0, 8'h00, 1'b1, 1'b0, RespNone, 8'h00, 16'h0000);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every popped word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (words_due.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, got %h",
                 $time, out_word_o);
        fail_count++;
      end else begin
        want = words_due.pop_front();
        check_field("tx_valid", 16'(want.tx_valid), 16'(out_word_o.tx_valid));
        check_field("tx_byte", 16'(want.tx_byte), 16'(out_word_o.tx_byte));
        check_field("last_of_run", 16'(want.last_of_run), 16'(out_word_o.last_of_run));
        check_field("play_rejected", 16'(want.play_rejected),
                    16'(out_word_o.play_rejected));
        check_field("resp_kind", 16'(want.resp_kind), 16'(out_word_o.resp_kind));
        check_field("resp_cmd", 16'(want.resp_cmd), 16'(out_word_o.resp_cmd));
        check_field("resp_param", want.resp_param, out_word_o.resp_param);
        check_field("playing", 16'(want.playing), 16'(out_word_o.playing));
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Abort if no word and no register access moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles", $time, QuietLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request word, idling first at random; predict once it is taken.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < source_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    predict_words(w);
  endtask

  function automatic in_word_t random_word(req_e req);
    in_word_t w;
    w.req_type      = req;
    w.folder_number = 8'($urandom);
    w.track_number  = 8'($urandom);
    w.volume_level  = 8'($urandom);
    w.rx_byte       = 8'($urandom);
    return w;
  endfunction

  task automatic send_req(req_e req, logic [7:0] folder, logic [7:0] track,
                          logic [7:0] vol, logic [7:0] rx);
    in_word_t w;
    w.req_type      = req;
    w.folder_number = folder;
    w.track_number  = track;
    w.volume_level  = vol;
    w.rx_byte       = rx;
    send_word(w);
  endtask

  // Drop push and hold until every predicted word has been popped
  task automatic wait_all_results();
    push <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  // Write a register, then read it back; psel stays high from write to read.
  task automatic config_reg(logic [2:0] addr, logic [31:0] data);
    logic [31:0] mask;
    mask = (addr == AddrMargin) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // the register takes the value at this edge
    if (addr == AddrMargin) shadow_margin_ms = data[15:0];
    else shadow_expected_ms = data;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (data & mask)) begin
      $display("%0t: register %h read back, expected %h, got %h",
               $time, addr, data & mask, prdata & mask);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain, give the back end time to settle, then write both registers
  task automatic set_timeout(logic [31:0] expected_ms, logic [15:0] margin_ms);
    wait_all_results();
    repeat (SettleCycles) @(posedge clk_i);
    config_reg(AddrExpected, expected_ms);
    config_reg(AddrMargin, {16'h0000, margin_ms});
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // One random burst: a play, another command, a received frame or a run of ticks.
  task automatic send_random_burst(output int count);
    in_word_t   w;
    int         pick;
    int         len;
    logic [7:0] bytes [10];
    count = 0;
    pick  = $urandom_range(99);
    if (pick < 30) begin
      w = random_word(ReqPlay);
      // mostly in range; the rest is random and often shows the rejection
      if ($urandom_range(9) != 0) begin
        w.folder_number = 8'($urandom_range(int'(MinIndex), int'(MaxIndex)));
        w.track_number  = 8'($urandom_range(int'(MinIndex), int'(MaxIndex)));
      end
      send_word(w);
      count = 1;
    end else if (pick < 45) begin
      send_word(random_word(req_e'($urandom_range(int'(ReqStop), int'(ReqFeedback)))));
      count = 1;
    end else if (pick < 75) begin
      // a little line noise ahead of the frame now and then
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < len; i++) send_word(random_word(ReqRxByte));
      for (int i = 0; i < 10; i++) bytes[i] = 8'($urandom);
      bytes[RxFirstPos] = FrameStart;
      if ($urandom_range(3) != 0) begin
        bytes[1] = FrameVersion;
        bytes[2] = FrameLength;
      end
      case ($urandom_range(3))
        0: bytes[RxCmdPos] = RptFinished;
        1: bytes[RxCmdPos] = RptError;
        2: bytes[RxCmdPos] = CmdFeedback;
        default: ;
      endcase
      // a start byte inside the frame must not restart it
      if ($urandom_range(7) == 0) bytes[4] = FrameStart;
      if ($urandom_range(6) != 0) bytes[RxLastPos] = FrameEnd;
      for (int i = 0; i < 10; i++) begin
        w         = random_word(ReqRxByte);
        w.rx_byte = bytes[i];
        send_word(w);
      end
      count = len + 10;
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_word(random_word(ReqTick));
      count = len;
    end
  endtask

  task automatic run_phase(int gap_pct, int stall_pct, logic [31:0] expected_ms,
                           logic [15:0] margin_ms);
    int sent;
    int burst;
    bit paused;
    set_timeout(expected_ms, margin_ms);
    source_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < PhaseWords) begin
      // halfway through, hold the sender until the result side has caught up
      if (!paused && sent >= PhaseWords / 2) begin
        wait_all_results();
        paused = 1'b1;
      end
      send_random_burst(burst);
      sent += burst;
    end
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Every command, the play range edges and the volume clamp
  task automatic test_commands();
    send_req(ReqPlay, 8'd1, 8'd1, 8'h00, 8'h00);
    send_req(ReqPlay, MaxIndex, MaxIndex, 8'hFF, 8'hFF);
    send_req(ReqPlay, 8'd0, 8'd1, 8'h00, 8'h00);
    send_req(ReqPlay, 8'd1, 8'd0, 8'h00, 8'h00);
    send_req(ReqPlay, 8'd100, MaxIndex, 8'h00, 8'h00);
    send_req(ReqPlay, MaxIndex, 8'hFF, 8'hFF, 8'hFF);
    send_req(ReqStop, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_req(ReqPause, 8'h00, 8'h00, 8'h00, 8'h00);
    send_req(ReqResume, 8'h00, 8'h00, 8'h00, 8'h00);
    send_req(ReqVolume, 8'h00, 8'h00, 8'd0, 8'h00);
    send_req(ReqVolume, 8'h00, 8'h00, 8'd31, 8'h00);
    send_req(ReqVolume, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_req(ReqFeedback, 8'h00, 8'h00, 8'h00, 8'h00);
    send_req(ReqTick, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_all_results();
  endtask

  // A discarded noise byte, then an error report that clears the playing flag
  task automatic test_rx_report();
    logic [7:0] bytes [10];
    bytes = '{FrameStart, FrameVersion, FrameLength, RptError, 8'h00,
              8'h00, 8'h03, 8'hFE, 8'hB9, FrameEnd};
    send_req(ReqRxByte, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 10; i++) send_req(ReqRxByte, 8'h00, 8'h00, 8'h00, bytes[i]);
    send_req(ReqTick, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    wait_all_results();
  endtask

  // Playback timeout: fires past expected plus margin, and not when disabled
  task automatic test_timeout();
    set_timeout(32'd2, 16'd0);
    send_req(ReqPlay, 8'd5, 8'd7, 8'h00, 8'h00);
    repeat (4) send_req(ReqTick, 8'h00, 8'h00, 8'h00, 8'h00);
    // resume keeps the count, so the next tick is already late
    send_req(ReqResume, 8'h00, 8'h00, 8'h00, 8'h00);
    send_req(ReqTick, 8'h00, 8'h00, 8'h00, 8'h00);
    set_timeout(32'd0, MarginResetMs);
    send_req(ReqPlay, 8'd2, 8'd3, 8'h00, 8'h00);
    repeat (5) send_req(ReqTick, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni    = 1'b0;
    push      = 1'b0;
    in_word_i = '0;
    pop       = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    shadow_expected_ms = 32'd0;
    shadow_margin_ms   = MarginResetMs;
    shadow_playing     = 1'b0;
    shadow_elapsed_ms  = '0;
    shadow_rx_pos      = RxFirstPos;
    for (int i = 0; i < 10; i++) shadow_rx_frame[i] = 8'h00;

    repeat (ResetCycles) @(posedge clk_i);
    // release away from the active edge
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_commands();
    test_rx_report();
    test_timeout();
    run_phase(15, 50, 32'd3, 16'd4);
    run_phase(50, 15, 32'hFFFF_FFFF, 16'hFFFF);
    run_phase(0, 0, 32'd1, 16'd0);

    // let any stray word show up before the verdict
    repeat (EndSettleCycles) @(posedge clk_i);
    if (fail_count == 0 && words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
